// ===== sv/rslbt_pkg.sv =====
package rslbt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 21;
  localparam int VEL_W      = 21;
  localparam int MAG_W      = 20;
  localparam int TIME_W     = 23;
  localparam int DT_W       = 16;
  localparam int SAMPLE_W   = 17;
  localparam int EDGE_W     = 20;
  localparam int VMAX_W     = 20;
  localparam int ACC_W      = 23;

  // shared multiplier operands and product
  localparam int MUL_A_W    = 24;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SHIFT_W    = PROD_W - FRAC_BITS;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_ADDR_W-1:0] REG_POS_MIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POS_MAX  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_BUF = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_MAX  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ACC_MAX  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 3'd5;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIMER,
    S_GOAL,
    S_ACC,
    S_MOVE,
    S_POS,
    S_DONE
  } state_t;

  // |x| saturated at 2^20-1
  function automatic logic [MAG_W-1:0] mag_f(input logic signed [VEL_W-1:0] x);
    logic signed [VEL_W-1:0] neg;
    neg = -x;
    if (!x[VEL_W-1]) begin
      mag_f = x[MAG_W-1:0];
    end else if (x == {1'b1, {MAG_W{1'b0}}}) begin
      mag_f = {MAG_W{1'b1}};
    end else begin
      mag_f = neg[MAG_W-1:0];
    end
  endfunction

  function automatic logic signed [VEL_W-1:0] pos_mag_f(input logic signed [VEL_W-1:0] x);
    pos_mag_f = $signed({1'b0, mag_f(x)});
  endfunction

  function automatic logic signed [VEL_W-1:0] neg_mag_f(input logic signed [VEL_W-1:0] x);
    neg_mag_f = -$signed({1'b0, mag_f(x)});
  endfunction

endpackage

// ===== sv/random_slew_limited_bouncing_trajectory_top.sv =====
// A restart word goes from the goal step straight to done, skipping slew, move and reflect.
// The input is held off while busy: a new word is taken only once the last result is loaded.
// All three products go through one 24x17 multiplier, one product per cycle, so the
// sequencer steps through timer, goal, slew, move and reflect in turn.
// Reset (rst_n low, synchronous): position, velocity, goal and timer to zero,
// configuration registers to their defaults, output empty.
module random_slew_limited_bouncing_trajectory_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tick_length [15:0], random_sample [32:16], zero pad [39:33]
  input  logic [rslbt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type [0]
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // position [20:0], velocity [41:21], zero pad [47:42]
  output logic [rslbt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // retargeted [0]
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rslbt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rslbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rslbt_pkg::*;

  // configuration registers
  logic signed [POS_W-1:0]  pos_min_r, pos_max_r;
  logic [EDGE_W-1:0]        edge_buf_r;
  logic [VMAX_W-1:0]        vel_max_r;
  logic [ACC_W-1:0]         acc_max_r;
  logic [TIME_W-1:0]        period_r;

  // trajectory state
  state_t                   state_r, state_nxt;
  logic signed [POS_W-1:0]  cur_pos_r, cur_pos_nxt;
  logic signed [VEL_W-1:0]  cur_vel_r, cur_vel_nxt;
  logic signed [VEL_W-1:0]  goal_r, goal_nxt;
  logic [TIME_W-1:0]        timer_r, timer_nxt;
  logic                     retgt_r, retgt_nxt;

  // latched input word
  logic                     req_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [SAMPLE_W-1:0] sample_r;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SHIFT_W-1:0] prod_sh;

  // output register
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_pos_r;
  logic signed [VEL_W-1:0]  out_vel_r;
  logic                     out_retgt_r;
  logic                     out_load;

  // datapath terms
  logic [TIME_W:0]          tsum;
  logic [TIME_W-1:0]        tsat;
  logic                     t_hit;
  logic signed [POS_W:0]    mid_sum;
  logic signed [POS_W+1:0]  hi_lim, lo_lim, pos23;
  logic                     near_hi, near_lo;
  logic signed [VEL_W-1:0]  g_new, g_up, g_in;
  logic signed [ACC_W:0]    acc_lim, vdiff, dv;
  logic signed [ACC_W+1:0]  vsum;
  logic                     vsum_fits;
  logic signed [VEL_W-1:0]  vel_sat;
  logic signed [ACC_W+1:0]  xn, xr, pmin25, pmax25;
  logic                     over, under;
  logic signed [POS_W-1:0]  xc;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r  <= -21'sd16384;
      pos_max_r  <= 21'sd16384;
      edge_buf_r <= 20'd655;
      vel_max_r  <= 20'd4588;
      acc_max_r  <= 23'd32768;
      period_r   <= 23'd393216;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_POS_MIN:  pos_min_r  <= $signed(cfg_data[POS_W-1:0]);
        REG_POS_MAX:  pos_max_r  <= $signed(cfg_data[POS_W-1:0]);
        REG_EDGE_BUF: edge_buf_r <= cfg_data[EDGE_W-1:0];
        REG_VEL_MAX:  vel_max_r  <= cfg_data[VMAX_W-1:0];
        REG_ACC_MAX:  acc_max_r  <= cfg_data[ACC_W-1:0];
        REG_PERIOD:   period_r   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- multiplier
  // TIMER: vel_max*sample, GOAL: acc_max*dt, otherwise velocity*dt
  always_comb begin
    unique case (state_r)
      S_TIMER: begin
        mul_a = $signed({{(MUL_A_W-VMAX_W){1'b0}}, vel_max_r});
        mul_b = sample_r;
      end
      S_GOAL: begin
        mul_a = $signed({{(MUL_A_W-ACC_W){1'b0}}, acc_max_r});
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_r});
      end
      default: begin
        mul_a = {{(MUL_A_W-VEL_W){cur_vel_r[VEL_W-1]}}, cur_vel_r};
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // floor shift by FRAC_BITS is a plain bit select on two's complement
  assign prod_sh = $signed(prod_r[PROD_W-1:FRAC_BITS]);

  // ---------------------------------------------------------------- datapath
  // elapsed time, saturating at full scale
  assign tsum  = {1'b0, timer_r} + {{(TIME_W+1-DT_W){1'b0}}, dt_r};
  assign tsat  = tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
  assign t_hit = (tsat >= period_r);

  // restart midpoint, floor of the half sum
  assign mid_sum = {pos_min_r[POS_W-1], pos_min_r} + {pos_max_r[POS_W-1], pos_max_r};

  // new goal, pointed inward near an end; the lower end wins
  assign pos23   = {{2{cur_pos_r[POS_W-1]}}, cur_pos_r};
  assign hi_lim  = {{2{pos_max_r[POS_W-1]}}, pos_max_r} - $signed({3'b000, edge_buf_r});
  assign lo_lim  = {{2{pos_min_r[POS_W-1]}}, pos_min_r} + $signed({3'b000, edge_buf_r});
  assign near_hi = (pos23 > hi_lim);
  assign near_lo = (pos23 < lo_lim);
  assign g_new   = prod_sh[VEL_W-1:0];
  assign g_up    = near_hi ? neg_mag_f(g_new) : g_new;
  assign g_in    = near_lo ? pos_mag_f(g_up) : g_up;

  // slew toward goal by at most acc_max*dt
  assign acc_lim = $signed({1'b0, prod_sh[ACC_W-1:0]});
  assign vdiff   = {{(ACC_W+1-VEL_W){goal_r[VEL_W-1]}}, goal_r}
                 - {{(ACC_W+1-VEL_W){cur_vel_r[VEL_W-1]}}, cur_vel_r};
  always_comb begin
    priority if (vdiff < -acc_lim) begin
      dv = -acc_lim;
    end else if (vdiff > acc_lim) begin
      dv = acc_lim;
    end else begin
      dv = vdiff;
    end
  end
  assign vsum      = {{(ACC_W+2-VEL_W){cur_vel_r[VEL_W-1]}}, cur_vel_r}
                   + {dv[ACC_W], dv};
  assign vsum_fits = (vsum[ACC_W+1:VEL_W-1] == '0) || (vsum[ACC_W+1:VEL_W-1] == '1);
  assign vel_sat   = vsum_fits ? vsum[VEL_W-1:0]
                   : (vsum[ACC_W+1] ? {1'b1, {MAG_W{1'b0}}} : {1'b0, {MAG_W{1'b1}}});

  // integrate, mirror an overshoot, clamp (lower end tested first)
  assign pmin25 = {{(ACC_W+2-POS_W){pos_min_r[POS_W-1]}}, pos_min_r};
  assign pmax25 = {{(ACC_W+2-POS_W){pos_max_r[POS_W-1]}}, pos_max_r};
  assign xn     = {{(ACC_W+2-POS_W){cur_pos_r[POS_W-1]}}, cur_pos_r}
                + {{(ACC_W+2-VEL_W){prod_sh[VEL_W-1]}}, prod_sh[VEL_W-1:0]};
  assign over   = (xn > pmax25);
  assign under  = (xn < pmin25);
  assign xr     = over ? ((pmax25 <<< 1) - xn) : (under ? ((pmin25 <<< 1) - xn) : xn);
  assign xc     = (xr < pmin25) ? pos_min_r : ((xr > pmax25) ? pos_max_r : xr[POS_W-1:0]);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_pos_nxt = cur_pos_r;
    cur_vel_nxt = cur_vel_r;
    goal_nxt    = goal_r;
    timer_nxt   = timer_r;
    retgt_nxt   = retgt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_TIMER;
        end
      end
      S_TIMER: begin
        if (req_r == REQ_RESTART) begin
          cur_pos_nxt = mid_sum[POS_W:1];
          cur_vel_nxt = '0;
          timer_nxt   = '0;
          retgt_nxt   = 1'b1;
        end else begin
          timer_nxt = t_hit ? '0 : tsat;
          retgt_nxt = t_hit;
        end
        state_nxt = S_GOAL;
      end
      S_GOAL: begin
        if (req_r == REQ_RESTART) begin
          goal_nxt  = g_new;
          state_nxt = S_DONE;
        end else begin
          if (retgt_r) begin
            goal_nxt = g_in;
          end
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cur_vel_nxt = vel_sat;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        state_nxt = S_POS;
      end
      S_POS: begin
        if (over) begin
          cur_vel_nxt = neg_mag_f(cur_vel_r);
          goal_nxt    = neg_mag_f(goal_r);
        end else if (under) begin
          cur_vel_nxt = pos_mag_f(cur_vel_r);
          goal_nxt    = pos_mag_f(goal_r);
        end
        cur_pos_nxt = xc;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_pos_r <= '0;
      cur_vel_r <= '0;
      goal_r    <= '0;
      timer_r   <= '0;
      retgt_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_pos_r <= cur_pos_nxt;
      cur_vel_r <= cur_vel_nxt;
      goal_r    <= goal_nxt;
      timer_r   <= timer_nxt;
      retgt_r   <= retgt_nxt;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r    <= in_tuser;
      dt_r     <= in_tdata[DT_W-1:0];
      sample_r <= $signed(in_tdata[DT_W+SAMPLE_W-1:DT_W]);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r   <= cur_pos_r;
      out_vel_r   <= cur_vel_r;
      out_retgt_r <= retgt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_retgt_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_W-VEL_W){1'b0}}, out_vel_r, out_pos_r};

  // ---------------------------------------------------------------- checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_TIMER)
    else $error("accepted word did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("output word raised outside the done step");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_tready |=> state_r == S_DONE)
    else $error("result dropped while output register was full");

  a_restart_retargets: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GOAL && req_r == REQ_RESTART |-> retgt_r)
    else $error("restart did not flag a new goal");

endmodule

// ===== bench/tb_random_slew_limited_bouncing_trajectory_top.sv =====
`timescale 1ns / 1ps

module tb_random_slew_limited_bouncing_trajectory_top;
  import rslbt_pkg::*;

  localparam int     RESET_CYCLES = 11;
  localparam int     STUCK_LIMIT  = 4000;  // cycles without any handshake
  localparam int     LONG_HOLD    = 400;   // one long out_tready drop
  localparam int     TAIL_CYCLES  = 16;    // settle time after the last word
  localparam int     PHASES       = 8;
  localparam int     PHASE_WORDS  = 250;
  localparam longint TIME_SAT     = (64'sd1 <<< TIME_W) - 1;
  localparam longint VEL_LIM      = (64'sd1 <<< MAG_W) - 1;

  // one input word: command, time step, random draw
  typedef struct packed {
    logic                       req;
    logic [DT_W-1:0]            dt;
    logic signed [SAMPLE_W-1:0] sample;
  } tick_word_t;

  // one output word
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
    logic                    retargeted;
  } motion_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = REQ_TICK;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr = REG_POS_MIN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  random_slew_limited_bouncing_trajectory_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Trajectory predictor: private copy of settings and motion state.
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] travel_lo, travel_hi;
  logic [EDGE_W-1:0]       edge_zone;
  logic [VMAX_W-1:0]       speed_cap;
  logic [ACC_W-1:0]        accel_cap;
  logic [TIME_W-1:0]       retarget_time;
  logic signed [POS_W-1:0] pos_now;
  logic signed [VEL_W-1:0] vel_now, vel_goal;
  logic [TIME_W-1:0]       time_since;

  function automatic longint sat_mag(input longint x);
    longint a;
    a = (x < 0) ? -x : x;
    return (a > VEL_LIM) ? VEL_LIM : a;
  endfunction

  // Advance the trajectory by one word and return the word the block should emit.
  function automatic motion_t advance_trajectory(input tick_word_t w);
    longint  lo, hi, zone, vcap, acap, period, pos, dt, smp;
    longint  goal, vel, accel, dv, xn, elapsed;
    motion_t r;
    lo     = travel_lo;
    hi     = travel_hi;
    zone   = edge_zone;
    vcap   = speed_cap;
    acap   = accel_cap;
    period = retarget_time;
    pos    = pos_now;
    dt     = w.dt;
    smp    = $signed(w.sample);
    r.retargeted = 1'b0;
    if (w.req == REQ_RESTART) begin
      // back to midpoint, fresh goal with no inward bias, dt unused
      pos_now      = (lo + hi) >>> 1;
      vel_now      = '0;
      time_since   = '0;
      vel_goal     = (vcap * smp) >>> FRAC_BITS;
      r.retargeted = 1'b1;
    end else begin
      goal    = vel_goal;
      vel     = vel_now;
      elapsed = longint'(time_since) + dt;
      if (elapsed > TIME_SAT) elapsed = TIME_SAT;
      if (elapsed >= period) begin
        elapsed      = 0;
        r.retargeted = 1'b1;
        goal         = (vcap * smp) >>> FRAC_BITS;
        // lower-end rule runs last, so it wins when both ends are close
        if (pos > hi - zone) goal = -sat_mag(goal);
        if (pos < lo + zone) goal = sat_mag(goal);
      end
      time_since = elapsed;

      accel = (acap * dt) >>> FRAC_BITS;
      dv    = goal - vel;
      if (dv > accel) dv = accel;
      else if (dv < -accel) dv = -accel;
      vel = vel + dv;
      if (vel > VEL_LIM) vel = VEL_LIM;
      else if (vel < -VEL_LIM - 1) vel = -VEL_LIM - 1;

      xn = pos + ((vel * dt) >>> FRAC_BITS);
      // mirror an overshoot, upper end tested first
      if (xn > hi) begin
        xn   = hi - (xn - hi);
        vel  = -sat_mag(vel);
        goal = -sat_mag(goal);
      end else if (xn < lo) begin
        xn   = lo + (lo - xn);
        vel  = sat_mag(vel);
        goal = sat_mag(goal);
      end
      // clamp tests the lower end first (matters for an inverted range)
      if (xn < lo) xn = lo;
      else if (xn > hi) xn = hi;
      pos_now  = xn;
      vel_now  = vel;
      vel_goal = goal;
    end
    r.position = pos_now;
    r.velocity = vel_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: handshakes, predictor update, compare, watchdog.
  // Sampled at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  tick_word_t              seen_word;
  motion_t                 expected_motion[$];
  motion_t                 want;
  logic signed [POS_W-1:0] got_pos;
  logic signed [VEL_W-1:0] got_vel;
  bit                      in_fire, out_fire, cfg_fire;
  int                      mismatch_count = 0;
  int                      stuck_cycles = 0;

  always @(posedge clk) begin
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;

    if (!rst_n) begin
      travel_lo     = -16384;
      travel_hi     = 16384;
      edge_zone     = 655;
      speed_cap     = 4588;
      accel_cap     = 32768;
      retarget_time = 393216;
      pos_now       = '0;
      vel_now       = '0;
      vel_goal      = '0;
      time_since    = '0;
    end

    if (cfg_fire) begin
      case (cfg_addr)
        REG_POS_MIN:  travel_lo     = cfg_data[POS_W-1:0];
        REG_POS_MAX:  travel_hi     = cfg_data[POS_W-1:0];
        REG_EDGE_BUF: edge_zone     = cfg_data[EDGE_W-1:0];
        REG_VEL_MAX:  speed_cap     = cfg_data[VMAX_W-1:0];
        REG_ACC_MAX:  accel_cap     = cfg_data[ACC_W-1:0];
        REG_PERIOD:   retarget_time = cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end

    // compare before queuing, a word taken now can't be the one leaving now
    if (out_fire) begin
      got_pos = out_tdata[POS_W-1:0];
      got_vel = out_tdata[POS_W+VEL_W-1:POS_W];
      if (expected_motion.size() == 0) begin
        $error("output word with nothing pending: tdata %h tuser %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_motion.pop_front();
        if (got_pos !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got_pos);
          mismatch_count++;
        end
        if (got_vel !== want.velocity) begin
          $error("velocity: expected %0d, got %0d", want.velocity, got_vel);
          mismatch_count++;
        end
        if (out_tuser !== want.retargeted) begin
          $error("retargeted: expected %0b, got %0b", want.retargeted, out_tuser);
          mismatch_count++;
        end
      end
    end

    if (in_fire) begin
      seen_word.req    = in_tuser;
      seen_word.dt     = in_tdata[DT_W-1:0];
      seen_word.sample = in_tdata[DT_W+SAMPLE_W-1:DT_W];
      expected_motion.push_back(advance_trajectory(seen_word));
    end

    if (!rst_n || in_fire || out_fire || cfg_fire) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_random_slew_limited_bouncing_trajectory_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps, a word is held until
  // taken. Changes land on the falling edge.
  // ---------------------------------------------------------------------------
  tick_word_t tick_words[$];
  tick_word_t next_word;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // word still on offer
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (tick_words.size() == 0) begin
      in_tvalid <= 1'b0;
    end else begin
      next_word = tick_words.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= next_word.req;
      in_tdata  <= {{(IN_TDATA_W-DT_W-SAMPLE_W){1'b0}}, next_word.sample, next_word.dt};
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // a quarter of the bursts run straight into the next one
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall patterns every so often; one long
  // hold-off on request so the block backs up into its input.
  // ---------------------------------------------------------------------------
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int ready_phase = 0;

  always @(negedge clk) begin
    ready_phase++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       out_tready <= 1'b1;                        // always ready
        1:       out_tready <= $urandom_range(0, 1);        // coin toss
        2:       out_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
        default: out_tready <= ((ready_phase % 5) < 3);     // ready three fifths of the time, in a repeating pattern
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_word(input logic req, input int dt, input int sample);
    tick_word_t w;
    w.req    = req;
    w.dt     = DT_W'(dt);
    w.sample = SAMPLE_W'(sample);
    tick_words.push_back(w);
  endfunction

  // block idle: nothing queued, nothing on offer, nothing outstanding
  task automatic wait_idle();
    while (tick_words.size() != 0 || in_tvalid || expected_motion.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_fire);
  endtask

  // signed ends go out sign-extended to the full data width
  task automatic program_travel(input int lo, input int hi, input int zone,
                                input int vcap, input int acap, input int period);
    write_reg(REG_POS_MIN, CFG_DATA_W'(lo));
    write_reg(REG_POS_MAX, CFG_DATA_W'(hi));
    write_reg(REG_EDGE_BUF, CFG_DATA_W'(zone));
    write_reg(REG_VEL_MAX, CFG_DATA_W'(vcap));
    write_reg(REG_ACC_MAX, CFG_DATA_W'(acap));
    write_reg(REG_PERIOD, CFG_DATA_W'(period));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int  lo, hi, zone, vcap, acap, period;
    bit  long_ticks;
    int  dt_pick;
    logic req;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: restart at both sample extremes, zero and full dt,
    // and enough full-length ticks to cross the default retarget period
    push_word(REQ_RESTART, 65535, -65536);
    push_word(REQ_TICK, 0, 65535);
    for (int i = 0; i < 7; i++)
      push_word(REQ_TICK, 65535, (i % 2 == 0) ? 65535 : -65536);
    push_word(REQ_RESTART, 0, 65535);
    push_word(REQ_TICK, 1, 0);
    wait_idle();

    // tiny range, edge zone covers both ends, every tick retargets,
    // caps at their top: hard bounces and the lower-end rule winning
    program_travel(-100, 100, 1048575, 1048575, 8388607, 0);
    push_word(REQ_RESTART, 12, -65536);
    push_word(REQ_TICK, 65535, -65536);
    push_word(REQ_TICK, 65535, 65535);
    push_word(REQ_TICK, 1, 0);
    push_word(REQ_TICK, 32768, -1);
    wait_idle();

    // inverted range: tick results pinned to one of the ends
    program_travel(1000, -1000, 0, 1048575, 8388607, 65536);
    push_word(REQ_RESTART, 12345, 0);
    push_word(REQ_TICK, 65535, 65535);
    push_word(REQ_TICK, 65535, -65536);
    push_word(REQ_TICK, 100, -65536);
    push_word(REQ_TICK, 65535, 0);
    wait_idle();

    // random phases, each under its own settings
    for (int k = 0; k < PHASES; k++) begin
      long_ticks = 1'b0;
      case (k)
        0: begin
          lo = -524288; hi = 524288; zone = 20000;
          vcap = 524288; acap = 4194304; period = 3277;
        end
        1: begin
          // field extremes; long ticks, no restarts, so the timer saturates
          lo = -1048576; hi = 1048575; zone = 0;
          vcap = 1048575; acap = 8388607; period = 8388607;
          long_ticks = 1'b1;
        end
        2: begin
          lo = -$urandom_range(0, 5000); hi = $urandom_range(0, 5000);
          zone = $urandom_range(0, 3000); vcap = $urandom_range(0, 200000);
          acap = $urandom_range(0, 2000000); period = $urandom_range(0, 200000);
        end
        3: begin
          lo = -1000; hi = 1000; zone = 500;
          vcap = 100000; acap = 50000; period = 0;
        end
        4: begin
          lo = $urandom_range(0, 50000); hi = -$urandom_range(0, 50000);
          zone = $urandom_range(0, 20000); vcap = $urandom_range(0, 1048575);
          acap = $urandom_range(0, 8388607); period = $urandom_range(0, 100000);
        end
        5: begin
          lo = 0; hi = 0; zone = 0; vcap = 0; acap = 0; period = 0;
        end
        6: begin
          lo = -16384; hi = 16384; zone = 655;
          vcap = 4588; acap = 32768; period = 393216;
        end
        default: begin
          lo = -$urandom_range(0, 1048576); hi = $urandom_range(0, 1048575);
          zone = $urandom_range(0, 1048575); vcap = $urandom_range(0, 1048575);
          acap = $urandom_range(0, 8388607); period = $urandom_range(0, 8388607);
        end
      endcase
      program_travel(lo, hi, zone, vcap, acap, period);

      // mostly ticks, a restart now and then; dt spread over short and full
      for (int i = 0; i < PHASE_WORDS; i++) begin
        req = (!long_ticks && $urandom_range(0, 31) == 0) ? REQ_RESTART : REQ_TICK;
        dt_pick = $urandom_range(0, 3);
        if (long_ticks) push_word(req, $urandom_range(60000, 65535), $urandom);
        else if (dt_pick == 0) push_word(req, $urandom_range(0, 65535), $urandom);
        else if (dt_pick == 1) push_word(req, $urandom_range(0, 100), $urandom);
        else push_word(req, $urandom_range(0, 2000), $urandom);
      end
      // words keep coming while the receiver sits out a long stretch
      if (k == 2) hold_req = 1'b1;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_motion.size() == 0) begin
      $display("tb_random_slew_limited_bouncing_trajectory_top passed");
    end else begin
      $display("tb_random_slew_limited_bouncing_trajectory_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rslbt_pkg.sv
sv/random_slew_limited_bouncing_trajectory_top.sv
bench/tb_random_slew_limited_bouncing_trajectory_top.sv
